>>> sv/assert_macros.svh
// assertion macros shared by the assembler rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define SFTA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// when ante holds, cons must hold in the same cycle
`define SFTA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> sv/sfta_pkg.sv
// shared types and constants for the strip/fan triangle assembler
// no dependencies; imported by every module of the block
package sfta_pkg;

    localparam int MAX_VERTS  = 131072;
    localparam int WORD_W     = 16;
    localparam int RUN_W      = 16;
    localparam int SLOT_W     = 17;
    localparam int IPOS_W     = 19;
    localparam int KIND_W     = 2;
    localparam int VCNT_W     = $clog2(MAX_VERTS + 1);
    localparam int VSUM_W     = ((VCNT_W > RUN_W) ? VCNT_W : RUN_W) + 1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [KIND_W-1:0] KIND_VERTEX = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TRI    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_OVF    = 2'd3;

    // one queued command: a result-producing word after classification
    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic                     has_tri;
        logic [SLOT_W-1:0]        slot;
        logic signed [WORD_W-1:0] vert_ref;
        logic signed [WORD_W-1:0] norm_ref;
        logic signed [WORD_W-1:0] tex_s;
        logic signed [WORD_W-1:0] tex_t;
        logic [SLOT_W-1:0]        corner_a;
        logic [SLOT_W-1:0]        corner_b;
        logic [SLOT_W-1:0]        corner_c;
        logic [IPOS_W-1:0]        index_pos;
    } t_cmd;

    // one result word on the output channel
    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [SLOT_W-1:0]        slot;
        logic signed [WORD_W-1:0] vert_ref;
        logic signed [WORD_W-1:0] norm_ref;
        logic signed [WORD_W-1:0] tex_s;
        logic signed [WORD_W-1:0] tex_t;
        logic [SLOT_W-1:0]        corner_a;
        logic [SLOT_W-1:0]        corner_b;
        logic [SLOT_W-1:0]        corner_c;
        logic [IPOS_W-1:0]        index_pos;
        logic                     last;
    } t_res;

endpackage

>>> sv/sfta_front.sv
// front end: accepts command words, tracks run state and counters,
// queues one command per result-producing word; uses sfta_pkg
`include "assert_macros.svh"
module sfta_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [sfta_pkg::WORD_W-1:0] i_word,
    input  logic                              i_new_build,
    input  logic                              i_q_ready,
    output logic                              o_push,
    output sfta_pkg::t_cmd                    o_cmd
);
    import sfta_pkg::*;

    logic [VCNT_W-1:0]  r_vcnt, n_vcnt, eff_vcnt;
    logic [IPOS_W-1:0]  r_icnt, n_icnt, eff_icnt;
    logic [VCNT_W-1:0]  r_start, n_start;
    logic [RUN_W-1:0]   r_len, n_len;
    logic [RUN_W-1:0]   r_pos, n_pos, eff_pos;
    logic [1:0]         r_phase, n_phase, eff_phase;
    logic               r_in_run, n_in_run, eff_in_run;
    logic               r_fan, n_fan;
    logic               r_drop, n_drop, eff_drop;
    logic signed [WORD_W-1:0] r_held [3];
    logic signed [WORD_W-1:0] n_held [3];

    logic               acc;
    logic [RUN_W-1:0]   wu;
    logic [RUN_W-1:0]   count;
    logic [VSUM_W-1:0]  sum;
    logic               ovf;
    logic [SLOT_W-1:0]  slot;
    t_cmd               cmd;
    logic               push;

    assign o_ready = i_q_ready;
    assign acc     = i_valid && i_q_ready;
    assign o_push  = push;
    assign o_cmd   = cmd;

    always_comb begin
        // new build clears counters and run state before the word
        eff_vcnt   = i_new_build ? '0 : r_vcnt;
        eff_icnt   = i_new_build ? '0 : r_icnt;
        eff_pos    = i_new_build ? '0 : r_pos;
        eff_phase  = i_new_build ? '0 : r_phase;
        eff_in_run = i_new_build ? 1'b0 : r_in_run;
        eff_drop   = i_new_build ? 1'b0 : r_drop;

        wu    = RUN_W'(i_word);
        count = i_word[WORD_W-1] ? RUN_W'(~wu + RUN_W'(1)) : wu;
        sum   = VSUM_W'(eff_vcnt) + VSUM_W'(count);
        ovf   = sum > VSUM_W'(MAX_VERTS);
        slot  = SLOT_W'(eff_vcnt);

        n_vcnt   = r_vcnt;
        n_icnt   = r_icnt;
        n_start  = r_start;
        n_len    = r_len;
        n_pos    = r_pos;
        n_phase  = r_phase;
        n_in_run = r_in_run;
        n_fan    = r_fan;
        n_drop   = r_drop;
        n_held   = r_held;
        push     = 1'b0;
        cmd      = '0;

        if (acc) begin
            n_vcnt   = eff_vcnt;
            n_icnt   = eff_icnt;
            n_pos    = eff_pos;
            n_phase  = eff_phase;
            n_in_run = eff_in_run;
            n_drop   = eff_drop;
            if (!eff_in_run) begin
                // header word
                if (wu == '0) begin
                    push     = 1'b1;
                    cmd.kind = KIND_END;
                end else begin
                    n_fan    = i_word[WORD_W-1];
                    n_in_run = 1'b1;
                    n_len    = count;
                    n_pos    = '0;
                    n_phase  = '0;
                    if (ovf) begin
                        n_drop   = 1'b1;
                        push     = 1'b1;
                        cmd.kind = KIND_OVF;
                    end else begin
                        n_drop  = 1'b0;
                        n_start = eff_vcnt;
                    end
                end
            end else if (eff_phase != 2'd3) begin
                n_held[eff_phase] = i_word;
                n_phase           = eff_phase + 2'd1;
            end else begin
                // closing word of a vertex group
                n_phase = '0;
                if (!eff_drop) begin
                    push         = 1'b1;
                    cmd.kind     = KIND_VERTEX;
                    cmd.slot     = slot;
                    cmd.vert_ref = r_held[0];
                    cmd.norm_ref = r_held[1];
                    cmd.tex_s    = r_held[2];
                    cmd.tex_t    = i_word;
                    if (eff_pos >= RUN_W'(2)) begin
                        cmd.has_tri = 1'b1;
                        if (r_fan) begin
                            cmd.corner_a = SLOT_W'(r_start);
                            cmd.corner_b = slot - SLOT_W'(1);
                        end else if (!eff_pos[0]) begin
                            cmd.corner_a = slot - SLOT_W'(2);
                            cmd.corner_b = slot - SLOT_W'(1);
                        end else begin
                            cmd.corner_a = slot - SLOT_W'(1);
                            cmd.corner_b = slot - SLOT_W'(2);
                        end
                        cmd.corner_c  = slot;
                        cmd.index_pos = eff_icnt;
                        n_icnt        = eff_icnt + IPOS_W'(3);
                    end
                    n_vcnt = eff_vcnt + VCNT_W'(1);
                end
                n_pos = eff_pos + RUN_W'(1);
                if (n_pos >= r_len) begin
                    n_in_run = 1'b0;
                    n_drop   = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcnt   <= '0;
            r_icnt   <= '0;
            r_start  <= '0;
            r_len    <= '0;
            r_pos    <= '0;
            r_phase  <= '0;
            r_in_run <= 1'b0;
            r_fan    <= 1'b0;
            r_drop   <= 1'b0;
        end else begin
            r_vcnt   <= n_vcnt;
            r_icnt   <= n_icnt;
            r_start  <= n_start;
            r_len    <= n_len;
            r_pos    <= n_pos;
            r_phase  <= n_phase;
            r_in_run <= n_in_run;
            r_fan    <= n_fan;
            r_drop   <= n_drop;
        end
    end

    // held words are always written before they are read
    always_ff @(posedge i_clk) begin
        r_held <= n_held;
    end

    `SFTA_ASSERT_IMP(a_idle_phase, i_clk, i_rst_n, !r_in_run, r_phase == 2'd0, "phase set outside a run")
    `SFTA_ASSERT(a_vcnt_cap, i_clk, i_rst_n, r_vcnt <= VCNT_W'(MAX_VERTS), "vertex count past capacity")

endmodule

>>> sv/sfta_fifo.sv
// short command queue between front and back ends
// depends on sfta_pkg for the command type and depth
`include "assert_macros.svh"
module sfta_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sfta_pkg::t_cmd i_data,
    output logic           o_not_full,
    input  logic           i_pop,
    output logic           o_not_empty,
    output sfta_pkg::t_cmd o_head
);
    import sfta_pkg::*;

    t_cmd               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wptr, r_rptr;
    logic [FIFO_CW-1:0] r_count;

    assign o_not_full  = r_count != FIFO_CW'(FIFO_DEPTH);
    assign o_not_empty = r_count != '0;
    assign o_head      = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_wptr + FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_rptr + FIFO_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + FIFO_CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - FIFO_CW'(1);
            end
        end
    end

    `SFTA_ASSERT(a_no_underflow, i_clk, i_rst_n, !(i_pop && r_count == '0), "pop from empty queue")

endmodule

>>> sv/sfta_back.sv
// back end: expands queued commands into one or two result words
// and holds them in the output register; uses sfta_pkg
`include "assert_macros.svh"
module sfta_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_head_valid,
    input  sfta_pkg::t_cmd i_head,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output sfta_pkg::t_res o_res
);
    import sfta_pkg::*;

    logic r_out_valid, n_out_valid;
    logic r_pend, n_pend;
    t_res r_res, n_res;
    logic load;

    assign load    = !r_out_valid || i_ready;
    assign o_valid = r_out_valid;
    assign o_res   = r_res;

    always_comb begin
        o_pop       = 1'b0;
        n_pend      = r_pend;
        n_out_valid = r_out_valid && !i_ready;
        n_res       = r_res;
        if (load) begin
            if (r_pend) begin
                // second word: the triangle closed by the vertex
                n_res           = '0;
                n_res.kind      = KIND_TRI;
                n_res.corner_a  = i_head.corner_a;
                n_res.corner_b  = i_head.corner_b;
                n_res.corner_c  = i_head.corner_c;
                n_res.index_pos = i_head.index_pos;
                n_res.last      = 1'b1;
                n_out_valid     = 1'b1;
                n_pend          = 1'b0;
                o_pop           = 1'b1;
            end else if (i_head_valid) begin
                n_res          = '0;
                n_res.kind     = i_head.kind;
                n_res.slot     = i_head.slot;
                n_res.vert_ref = i_head.vert_ref;
                n_res.norm_ref = i_head.norm_ref;
                n_res.tex_s    = i_head.tex_s;
                n_res.tex_t    = i_head.tex_t;
                n_res.last     = !i_head.has_tri;
                n_out_valid    = 1'b1;
                if (i_head.has_tri) begin
                    n_pend = 1'b1;
                end else begin
                    o_pop = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    `SFTA_ASSERT_IMP(a_pend_vertex, i_clk, i_rst_n, r_pend, r_out_valid && !r_res.last && r_res.kind == KIND_VERTEX, "pending triangle without its vertex word")
    `SFTA_ASSERT_IMP(a_pend_head, i_clk, i_rst_n, r_pend, i_head_valid && i_head.has_tri, "pending triangle lost its queue entry")

endmodule

>>> sv/strip_fan_triangle_assembler.sv
// top level of the strip/fan triangle assembler
// instantiates sfta_front, sfta_fifo and sfta_back; uses sfta_pkg
//
// Takes one 16-bit command word per cycle while the queue has room (header,
// then four words per vertex) and emits vertex records, triangles, list-end
// and overflow words. The front end accepts a word every cycle while the
// four-entry command queue has room, updating all run state and counters in
// that cycle. The back end turns each queued command into results through
// a registered output: a vertex that closes a triangle yields two result
// words, every other command one. As a vertex spans four input words, the
// sustained rate is one input word per cycle while the output is not
// stalled. Results pass through the command queue and the output register.
// Output stalls back up through the queue and only then lower o_ready.
module strip_fan_triangle_assembler (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [sfta_pkg::WORD_W-1:0]  i_word,
    input  logic                                i_new_build,
    // output channel
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [sfta_pkg::KIND_W-1:0]         o_kind,
    output logic [sfta_pkg::SLOT_W-1:0]         o_slot,
    output logic signed [sfta_pkg::WORD_W-1:0]  o_vert_ref,
    output logic signed [sfta_pkg::WORD_W-1:0]  o_norm_ref,
    output logic signed [sfta_pkg::WORD_W-1:0]  o_tex_s,
    output logic signed [sfta_pkg::WORD_W-1:0]  o_tex_t,
    output logic [sfta_pkg::SLOT_W-1:0]         o_corner_a,
    output logic [sfta_pkg::SLOT_W-1:0]         o_corner_b,
    output logic [sfta_pkg::SLOT_W-1:0]         o_corner_c,
    output logic [sfta_pkg::IPOS_W-1:0]         o_index_pos,
    output logic                                o_last
);
    import sfta_pkg::*;

    // front to queue
    logic q_not_full;
    logic push;
    t_cmd cmd;
    // queue to back
    logic q_not_empty;
    logic pop;
    t_cmd head;
    // registered result word
    t_res res;

    sfta_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_word      (i_word),
        .i_new_build (i_new_build),
        .i_q_ready   (q_not_full),
        .o_push      (push),
        .o_cmd       (cmd)
    );

    sfta_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_data      (cmd),
        .o_not_full  (q_not_full),
        .i_pop       (pop),
        .o_not_empty (q_not_empty),
        .o_head      (head)
    );

    sfta_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_not_empty),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_res        (res)
    );

    // unpack the result word onto the field ports
    assign o_kind      = res.kind;
    assign o_slot      = res.slot;
    assign o_vert_ref  = res.vert_ref;
    assign o_norm_ref  = res.norm_ref;
    assign o_tex_s     = res.tex_s;
    assign o_tex_t     = res.tex_t;
    assign o_corner_a  = res.corner_a;
    assign o_corner_b  = res.corner_b;
    assign o_corner_c  = res.corner_c;
    assign o_index_pos = res.index_pos;
    assign o_last      = res.last;

endmodule

>>> tb/strip_fan_triangle_assembler_tb.sv
// self-checking testbench for strip_fan_triangle_assembler
// depends on sfta_pkg and the assembler rtl; a clocked driver and monitor run valid/ready
// traffic, and an in-bench model of the run state predicts every result word
module strip_fan_triangle_assembler_tb;
    import sfta_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RANDOM_WORDS   = 790;
    localparam int DIRECTED_WORDS = 25;

    // one command word waiting to go out; calm marks the tail of the run with no idling
    typedef struct {
        logic [WORD_W-1:0] word;
        logic              new_build;
        bit                calm;
    } t_cmd_item;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_valid     = 1'b0;
    logic                       o_ready;
    logic signed [WORD_W-1:0]   i_word      = '0;
    logic                       i_new_build = 1'b0;
    logic                       o_valid;
    logic                       i_ready     = 1'b0;
    logic [KIND_W-1:0]          o_kind;
    logic [SLOT_W-1:0]          o_slot;
    logic signed [WORD_W-1:0]   o_vert_ref;
    logic signed [WORD_W-1:0]   o_norm_ref;
    logic signed [WORD_W-1:0]   o_tex_s;
    logic signed [WORD_W-1:0]   o_tex_t;
    logic [SLOT_W-1:0]          o_corner_a;
    logic [SLOT_W-1:0]          o_corner_b;
    logic [SLOT_W-1:0]          o_corner_c;
    logic [IPOS_W-1:0]          o_index_pos;
    logic                       o_last;

    t_cmd_item   cmd_words[$];      // command words not yet presented
    t_res        owed_results[$];   // results the block still owes, oldest first
    int          mismatches  = 0;
    int          send_gap    = 0;
    int          recv_gap    = 0;
    int          quiet_cycles = 0;
    bit          calm_mode   = 1'b0;

    // assembler state as seen by the predictor
    int unsigned        asm_vertices;
    int unsigned        asm_indices;
    int unsigned        asm_run_start;
    int unsigned        asm_run_len;
    int unsigned        asm_run_pos;
    int unsigned        asm_phase;
    bit                 asm_in_run;
    bit                 asm_fan;
    bit                 asm_dropping;
    logic [WORD_W-1:0]  asm_held[3];

    strip_fan_triangle_assembler DUT (.*);

    always #2 i_clk = ~i_clk;

    // fold one accepted command word into the run state, queue the results it causes
    function automatic void assemble_word(logic [WORD_W-1:0] w, logic nb);
        t_res        res;
        t_res        tri_res;
        int unsigned count;
        int unsigned slot;
        int unsigned ca;
        int unsigned cb;
        if (nb) begin
            asm_vertices = 0;
            asm_indices  = 0;
            asm_in_run   = 1'b0;
            asm_dropping = 1'b0;
            asm_phase    = 0;
            asm_run_pos  = 0;
        end
        res = '0;
        if (!asm_in_run) begin
            // header word
            if (w == '0) begin
                res.kind = KIND_END;
                res.last = 1'b1;
                owed_results.push_back(res);
                return;
            end
            asm_fan     = w[WORD_W-1];
            count       = asm_fan ? ((32'h10000 - {16'b0, w}) & 32'h1FFFF) : {16'b0, w};
            asm_in_run  = 1'b1;
            asm_run_len = count;
            asm_run_pos = 0;
            asm_phase   = 0;
            if (asm_vertices + count > MAX_VERTS) begin
                // the run's vertices are swallowed; only the overflow word results
                asm_dropping = 1'b1;
                res.kind     = KIND_OVF;
                res.last     = 1'b1;
                owed_results.push_back(res);
                return;
            end
            asm_dropping  = 1'b0;
            asm_run_start = asm_vertices;
            return;
        end
        if (asm_phase < 3) begin
            asm_held[asm_phase] = w;
            asm_phase++;
            return;
        end
        // fourth word closes the vertex group
        asm_phase = 0;
        if (!asm_dropping) begin
            slot         = asm_run_start + asm_run_pos;
            res.kind     = KIND_VERTEX;
            res.slot     = SLOT_W'(slot);
            res.vert_ref = asm_held[0];
            res.norm_ref = asm_held[1];
            res.tex_s    = asm_held[2];
            res.tex_t    = w;
            res.last     = (asm_run_pos < 2);
            owed_results.push_back(res);
            if (asm_run_pos >= 2) begin
                if (asm_fan) begin
                    ca = asm_run_start;
                    cb = slot - 1;
                end else if (asm_run_pos[0] == 1'b0) begin
                    ca = slot - 2;
                    cb = slot - 1;
                end else begin
                    // odd strip triangles swap winding
                    ca = slot - 1;
                    cb = slot - 2;
                end
                tri_res           = '0;
                tri_res.kind      = KIND_TRI;
                tri_res.corner_a  = SLOT_W'(ca);
                tri_res.corner_b  = SLOT_W'(cb);
                tri_res.corner_c  = SLOT_W'(slot);
                tri_res.index_pos = IPOS_W'(asm_indices);
                tri_res.last      = 1'b1;
                owed_results.push_back(tri_res);
                asm_indices += 3;
            end
            asm_vertices++;
        end
        asm_run_pos++;
        if (asm_run_pos >= asm_run_len) begin
            asm_in_run   = 1'b0;
            asm_dropping = 1'b0;
        end
    endfunction

    function automatic void queue_word(logic [WORD_W-1:0] w, logic nb, bit calm);
        t_cmd_item item;
        item.word      = w;
        item.new_build = nb;
        item.calm      = calm;
        cmd_words.push_back(item);
    endfunction

    // n vertex groups of four random words each
    function automatic void queue_vertices(int unsigned n, bit calm);
        for (int unsigned v = 0; v < n; v++)
            for (int k = 0; k < 4; k++)
                queue_word(WORD_W'($urandom), 1'b0, calm);
    endfunction

    function automatic void compare_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // stimulus: directed words, random runs, then a short tail with no idling
    initial begin : stimulus
        logic [WORD_W-1:0] extremes[4];
        int unsigned       len;
        bit                fan;
        bit                force_build;
        int                pick;
        extremes = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};

        // empty list, then a max-magnitude fan abandoned by a new build
        queue_word(16'h0000, 1'b1, 1'b0);
        queue_word(16'h8000, 1'b0, 1'b0);
        queue_vertices(1, 1'b0);
        queue_word(16'h1234, 1'b0, 1'b0);
        queue_word(16'hEDCB, 1'b0, 1'b0);
        // four-vertex strip covering even and odd windings, extreme payloads
        queue_word(16'd4, 1'b1, 1'b0);
        for (int v = 0; v < 4; v++)
            for (int k = 0; k < 4; k++)
                queue_word(extremes[(v + k) % 4], 1'b0, 1'b0);

        // random part: mostly well-formed runs, some abandoned runs and stray words
        force_build = 1'b1;
        while (cmd_words.size() < RANDOM_WORDS + DIRECTED_WORDS) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                queue_word('0, force_build | 1'($urandom_range(0, 1)), 1'b0);
            end else if (pick == 1) begin
                // any header, a few groups, a partial group; next run restarts the build
                queue_word(WORD_W'($urandom_range(1, 16'hFFFF)), force_build, 1'b0);
                queue_vertices($urandom_range(0, 2), 1'b0);
                repeat ($urandom_range(0, 3)) queue_word(WORD_W'($urandom), 1'b0, 1'b0);
                force_build = 1'b1;
            end else if (pick == 2) begin
                queue_word(WORD_W'($urandom), 1'($urandom_range(0, 1)), 1'b0);
                force_build = 1'b1;
            end else begin
                len = $urandom_range(1, 7);
                fan = 1'($urandom_range(0, 1));
                queue_word(fan ? WORD_W'(0 - len) : WORD_W'(len),
                           force_build | ($urandom_range(0, 15) == 0), 1'b0);
                force_build = 1'b0;
                queue_vertices(len, 1'b0);
            end
        end

        // tail with no idling: a fan and a strip in a fresh build, then the list end
        queue_word(16'hFFFB, 1'b1, 1'b1);
        queue_vertices(5, 1'b1);
        queue_word(16'd3, 1'b0, 1'b1);
        queue_vertices(3, 1'b1);
        queue_word(16'h0000, 1'b0, 1'b1);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_words.size() != 0 || i_valid || owed_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("strip_fan_triangle_assembler regression: pass");
        else
            $display("strip_fan_triangle_assembler regression: fail");
        $finish;
    end

    // driver: presents queued words, holds each until accepted, inserts idle bursts
    always @(posedge i_clk) begin : drive_words
        t_cmd_item nxt;
        if (i_rst_n) begin
            if (i_valid && o_ready)
                assemble_word(i_word, i_new_build);
            if (!i_valid || o_ready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    i_valid  <= 1'b0;
                end else if (cmd_words.size() != 0) begin
                    nxt = cmd_words.pop_front();
                    i_valid     <= 1'b1;
                    i_word      <= nxt.word;
                    i_new_build <= nxt.new_build;
                    if (nxt.calm)
                        calm_mode <= 1'b1;
                    else if ($urandom_range(0, 5) == 0)
                        send_gap <= $urandom_range(1, 10);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: stalls the output at random, checks each accepted word
    always @(posedge i_clk) begin : check_results
        t_res want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (owed_results.size() == 0) begin
                    $error("result word with nothing expected: kind %0d", o_kind);
                    mismatches++;
                end else begin
                    want = owed_results.pop_front();
                    compare_field("kind", want.kind, o_kind);
                    compare_field("slot", want.slot, o_slot);
                    compare_field("vert_ref", want.vert_ref, o_vert_ref);
                    compare_field("norm_ref", want.norm_ref, o_norm_ref);
                    compare_field("tex_s", want.tex_s, o_tex_s);
                    compare_field("tex_t", want.tex_t, o_tex_t);
                    compare_field("corner_a", want.corner_a, o_corner_a);
                    compare_field("corner_b", want.corner_b, o_corner_b);
                    compare_field("corner_c", want.corner_c, o_corner_c);
                    compare_field("index_pos", want.index_pos, o_index_pos);
                    compare_field("last", want.last, o_last);
                end
            end
            if (recv_gap != 0) begin
                recv_gap <= recv_gap - 1;
                i_ready  <= 1'b0;
            end else if (!calm_mode && $urandom_range(0, 7) == 0) begin
                recv_gap <= $urandom_range(0, 9);
                i_ready  <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // watchdog: too long with no word moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("strip_fan_triangle_assembler regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
